// ===== sv/ccrc_pkg.sv =====
// Constants, register indexes and helper functions for the configurable bit-serial CRC unit.
package ccrc_pkg;

  localparam int MAX_CRC_BITS = 32;
  localparam int CRC_W = 32;
  localparam int WIDTH_W = $clog2(MAX_CRC_BITS + 1);
  localparam int ORDER_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_VALUE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_XOR = 2'd3;

  localparam logic [ORDER_W-1:0] ORDER_MIN = 3'd1;
  localparam logic [ORDER_W-1:0] ORDER_MAX = 3'd4;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd4;

  typedef logic [CRC_W-1:0] crc_t;

  // CRC width in bits: order clamped to 1..4 bytes, then limited to MAX_CRC_BITS.
  function automatic logic [WIDTH_W-1:0] crc_width(input logic [ORDER_W-1:0] ob);
    logic [ORDER_W-1:0] obc;
    logic [WIDTH_W:0] w;
    obc = ob;
    if (obc < ORDER_MIN) obc = ORDER_MIN;
    if (obc > ORDER_MAX) obc = ORDER_MAX;
    w = {1'b0, obc, 3'b000};
    if (w > (WIDTH_W + 1)'(MAX_CRC_BITS)) w = (WIDTH_W + 1)'(MAX_CRC_BITS);
    return w[WIDTH_W-1:0];
  endfunction

  function automatic crc_t width_mask(input logic [WIDTH_W-1:0] w);
    logic [CRC_W:0] m;
    m = ({{CRC_W{1'b0}}, 1'b1} << w) - 1'b1;
    return m[CRC_W-1:0];
  endfunction

endpackage

// ===== sv/configurable_crc_bit_serial_unit.sv =====
// Configurable 8 to 32 bit MSB-first bit-serial CRC unit with registered input and result.
// A bit accepted into the input stage is folded into the CRC register by the single LFSR
//   step; a last bit's result word is registered once any pending result is taken.
// Throughput: one bit per cycle, unless a last bit waits for a pending result word.
// Reset (rst, synchronous): registers go to their defaults (order 4 bytes, others 0), the
//   pipeline empties and the next bit starts a fresh message.
module configurable_crc_bit_serial_unit
  import ccrc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 data_bit,
  input  logic                 last_bit,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [CRC_W-1:0]     crc_value,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CRC_W-1:0]     cfg_data
);

  crc_t               polynomial;
  logic [ORDER_W-1:0] order_bytes;
  crc_t               initial_value;
  crc_t               output_xor;

  crc_t running_crc;
  crc_t running_crc_next;
  logic in_message;

  logic s1_valid;
  logic s1_bit;
  logic s1_last;
  logic s1_advance;

  logic [WIDTH_W-1:0] width;
  crc_t mask;
  crc_t top_sel;
  crc_t crc_start;
  logic fb;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial <= '0;
      order_bytes <= ORDER_RESET;
      initial_value <= '0;
      output_xor <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POLYNOMIAL:    polynomial <= cfg_data;
        REG_ORDER_BYTES:   order_bytes <= cfg_data[ORDER_W-1:0];
        REG_INITIAL_VALUE: initial_value <= cfg_data;
        REG_OUTPUT_XOR:    output_xor <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage holding a non-last bit never waits on the result side.
  assign s1_advance = !s1_last || !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_bit <= data_bit;
      s1_last <= last_bit;
    end
  end

  // One LFSR step
  always_comb begin
    width = crc_width(order_bytes);
    mask = width_mask(width);
    top_sel = mask ^ (mask >> 1);
    crc_start = (in_message ? running_crc : initial_value) & mask;
    fb = (|(crc_start & top_sel)) ^ s1_bit;
    running_crc_next = (crc_start << 1) & mask;
    if (fb) begin
      running_crc_next = running_crc_next ^ (polynomial & mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_crc <= '0;
      in_message <= 1'b0;
    end else if (s1_valid && s1_advance) begin
      if (s1_last) begin
        running_crc <= initial_value & mask;
        in_message <= 1'b0;
      end else begin
        running_crc <= running_crc_next;
        in_message <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_last && s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_last && s1_advance) begin
      crc_value <= (running_crc_next ^ output_xor) & mask;
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid && !s1_valid)
    else $error("pipeline not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_last) && $stable(s1_bit))
    else $error("input stage lost its word while stalled");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_last))
    else $error("result word without a last bit");

  a_message_restart: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && s1_advance |=> !in_message)
    else $error("message state not cleared after last bit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(crc_value))
    else $error("pending result word overwritten");

endmodule

// ===== test/configurable_crc_bit_serial_unit_tb.sv =====
// Testbench for the configurable bit-serial CRC unit: random messages checked against a CRC scoreboard.
`timescale 1ns / 1ps

module configurable_crc_bit_serial_unit_tb
  import ccrc_pkg::*;
;

  class crc_scoreboard;
    crc_t               poly;
    logic [ORDER_W-1:0] order;
    crc_t               init_val;
    crc_t               out_xor;
    crc_t               lfsr;
    bit                 busy;
    crc_t               crc_q[$];
    int                 mismatches;

    function new();
      poly       = '0;
      order      = ORDER_RESET;
      init_val   = '0;
      out_xor    = '0;
      lfsr       = '0;
      busy       = 1'b0;
      mismatches = 0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, crc_t data);
      case (idx)
        REG_POLYNOMIAL:    poly = data;
        REG_ORDER_BYTES:   order = data[ORDER_W-1:0];
        REG_INITIAL_VALUE: init_val = data;
        REG_OUTPUT_XOR:    out_xor = data;
        default: ;
      endcase
    endfunction

    function int unsigned width_bits();
      int unsigned ob;
      int unsigned w;
      ob = order;
      if (ob < 1) ob = 1;
      if (ob > 4) ob = 4;
      w = ob * 8;
      if (w > MAX_CRC_BITS) w = MAX_CRC_BITS;
      return w;
    endfunction

    // one LFSR step per accepted bit; a last bit queues the finished CRC word
    function void note_bit(bit d, bit l);
      int unsigned w;
      logic [63:0] wide;
      crc_t        m;
      crc_t        c;
      bit          fb;
      w    = width_bits();
      wide = (64'd1 << w) - 64'd1;
      m    = wide[CRC_W-1:0];
      c    = (busy ? lfsr : init_val) & m;
      fb   = c[w-1] ^ d;
      c    = (c << 1) & m;
      if (fb) c = c ^ (poly & m);
      if (l) begin
        crc_q.push_back((c ^ out_xor) & m);
        lfsr = init_val & m;
        busy = 1'b0;
      end else begin
        lfsr = c;
        busy = 1'b1;
      end
    endfunction

    function void check_crc(crc_t actual);
      crc_t want;
      if (crc_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("crc word with nothing pending: %h", actual);
        return;
      end
      want = crc_q.pop_front();
      if (want !== actual) begin
        mismatches++;
        if (mismatches <= 10) $display("crc_value expected %h got %h", want, actual);
      end
    endfunction

    function int pending();
      return crc_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic                 data_bit;
  logic                 last_bit;
  logic                 out_valid;
  logic                 out_ready;
  crc_t                 crc_value;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  crc_t                 cfg_data;

  crc_scoreboard sb = new();

  int gap_max    = 0;
  int burst_left = 0;
  int stall_pct  = 0;
  int hold_left  = 0;
  int run_left   = 0;
  bit run_ready  = 1'b1;

  logic [CFG_IDX_W-1:0] reg_ids [4] = '{REG_POLYNOMIAL, REG_ORDER_BYTES,
                                       REG_INITIAL_VALUE, REG_OUTPUT_XOR};

  configurable_crc_bit_serial_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_bit  (data_bit),
    .last_bit  (last_bit),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .crc_value (crc_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: runs of ready/stall, plus an optional long hold-off
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 8);
          run_ready = ($urandom_range(99) >= stall_pct);
        end
        run_left--;
        out_ready <= run_ready;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_crc(crc_value);
  end

  function automatic int next_gap();
    if (gap_max == 0) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 12);
    return $urandom_range(1, gap_max);
  endfunction

  function automatic crc_t pick_word();
    case ($urandom_range(3))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_bit(bit d, bit l);
    int gap;
    in_valid <= 1'b1;
    data_bit <= d;
    last_bit <= l;
    do @(posedge clk); while (!in_ready);
    sb.note_bit(d, l);
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_input();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // writes only with nothing pending and the last bit folded in
  task automatic program_reg(logic [CFG_IDX_W-1:0] idx, crc_t data);
    drain_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.apply_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(crc_t value, int nbits);
    for (int i = nbits - 1; i >= 0; i--) send_bit(value[i], i == 0);
  endtask

  task automatic send_message(int len, bit mid_writes, ref int count);
    logic [CFG_IDX_W-1:0] idx;
    crc_t                 data;
    for (int i = 0; i < len; i++) begin
      send_bit(1'($urandom_range(1)), i == len - 1);
      count++;
      if (mid_writes && i != len - 1 && $urandom_range(39) == 0) begin
        idx  = reg_ids[$urandom_range(3)];
        data = pick_word();
        if (idx == REG_ORDER_BYTES && $urandom_range(1)) data = data & 32'h7;
        program_reg(idx, data);
      end
    end
  endtask

  initial begin
    int   count;
    int   len;
    crc_t order_word;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    data_bit  <= 1'b0;
    last_bit  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_POLYNOMIAL;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: zero polynomial, 32-bit width
    send_word(1, 1);

    // order 0 behaves as one byte; all-ones settings; full and partial bytes
    program_reg(REG_POLYNOMIAL, '1);
    program_reg(REG_ORDER_BYTES, 32'h0);
    program_reg(REG_INITIAL_VALUE, '1);
    program_reg(REG_OUTPUT_XOR, '1);
    send_word(32'hFF, 8);
    send_word(0, 1);
    send_word(32'h5, 3);

    // order 7 with stray upper data bits behaves as four bytes
    program_reg(REG_POLYNOMIAL, 32'h04C11DB7);
    program_reg(REG_ORDER_BYTES, 32'hFFFFFFFF);
    send_bit(1, 0);
    send_bit(0, 0);
    // width change mid-message; new initial value waits for the next message
    program_reg(REG_ORDER_BYTES, 32'h2);
    program_reg(REG_INITIAL_VALUE, 32'h0000A5A5);
    send_bit(1, 0);
    send_bit(1, 1);
    send_word(1, 1);

    for (int phase = 0; phase < 8; phase++) begin
      order_word = $urandom_range(1) ? (pick_word() & ~32'h7) : '0;
      order_word = order_word | (phase % 8);
      program_reg(REG_POLYNOMIAL, pick_word());
      program_reg(REG_ORDER_BYTES, order_word);
      program_reg(REG_INITIAL_VALUE, pick_word());
      program_reg(REG_OUTPUT_XOR, pick_word());
      stall_pct  = (phase % 4 == 0) ? 0 : $urandom_range(10, 60);
      gap_max    = (phase % 3 == 1) ? 0 : $urandom_range(1, 6);
      burst_left = 0;
      count      = 0;
      if (phase == 3) begin
        // receiver holds off while single-bit messages keep coming
        gap_max   = 0;
        hold_left = 300;
        while (count < 48) send_message(1, 1'b0, count);
      end else begin
        while (count < 48) begin
          len = ($urandom_range(7) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 12);
          send_message(len, 1'b1, count);
        end
      end
      if (phase == 5) begin
        // sender waits for every pending word before going on
        drain_input();
        while (sb.pending() != 0) @(posedge clk);
      end
    end

    drain_input();
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
